// ===== hw/rtl/sbsh_pkg.sv =====
// Shared types, constants and tables of the SHA-256 byte stream hasher.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package sbsh_pkg;

   typedef logic [31:0] word_type;

   // Byte position at which the 64-bit length field starts within a block.
   localparam logic [5:0] LEN_OFFSET = 6'd56;
   localparam logic [7:0] PAD_BYTE   = 8'h80;

   // Byte source codes for the block line.
   localparam logic [1:0] BSEL_DATA = 2'd0;
   localparam logic [1:0] BSEL_PAD  = 2'd1;
   localparam logic [1:0] BSEL_ZERO = 2'd2;
   localparam logic [1:0] BSEL_LEN  = 2'd3;

   localparam word_type IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam word_type K_TABLE [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       push;         // shift one byte into the block line
      logic [1:0] byte_sel;     // which byte is shifted in
      logic [2:0] len_idx;      // length byte, most significant first
      logic       count_len;    // one more message byte taken
      logic       init_work;    // working variables take the chain value
      logic       do_round;     // run one compression round
      logic [5:0] round_idx;
      logic       fold;         // add working variables into the chain
      logic       digest_load;  // hand the digest to the output, restart the chain
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_busy;           // digest parts still waiting to be taken
   } dp_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/sbsh_req_if.sv =====
// Input channel of the hasher: one message byte per transfer with a last flag.
// Stands alone; no package needed.
`default_nettype none

interface sbsh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sbsh_rsp_if.sv =====
// Result channel of the hasher: 64 digest bits per transfer with an end flag.
// Stands alone; no package needed.
`default_nettype none

interface sbsh_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_part;
   logic        digest_end;

   modport source (output valid, output digest_part, output digest_end, input ready);
   modport sink   (input valid, input digest_part, input digest_end, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sbsh_ctrl.sv =====
// Controller state machine of the hasher: byte intake, padding and round sequencing.
// Depends on sbsh_pkg for the command and status types and byte source codes.
`default_nettype none

module sbsh_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_last,
   output logic                        req_ready,
   output sbsh_pkg::ctrl_cmd_type      cmd,
   input  wire sbsh_pkg::dp_status_type status
);

   localparam logic [2:0] S_LOAD  = 3'd0;
   localparam logic [2:0] S_PAD80 = 3'd1;
   localparam logic [2:0] S_ZERO  = 3'd2;
   localparam logic [2:0] S_LEN   = 3'd3;
   localparam logic [2:0] S_ROUND = 3'd4;
   localparam logic [2:0] S_FOLD  = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [2:0] ret_ff, ret_in;
   logic [5:0] fill_ff, fill_in;
   logic [5:0] round_ff, round_in;
   logic [2:0] lidx_ff, lidx_in;
   logic       full;

   assign full = (fill_ff == 6'd63);

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      fill_in       = fill_ff;
      round_in      = round_ff;
      lidx_in       = lidx_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.round_idx = round_ff;
      cmd.len_idx   = lidx_ff;
      unique case (state_ff)
         S_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.push      = 1'b1;
               cmd.byte_sel  = sbsh_pkg::BSEL_DATA;
               cmd.count_len = 1'b1;
               fill_in       = fill_ff + 6'd1;
               if (full) begin
                  cmd.init_work = 1'b1;
                  ret_in        = req_last ? S_PAD80 : S_LOAD;
                  state_in      = S_ROUND;
               end else if (req_last) begin
                  state_in = S_PAD80;
               end
            end
         end
         S_PAD80: begin
            cmd.push     = 1'b1;
            cmd.byte_sel = sbsh_pkg::BSEL_PAD;
            fill_in      = fill_ff + 6'd1;
            if (full) begin
               cmd.init_work = 1'b1;
               ret_in        = S_ZERO;
               state_in      = S_ROUND;
            end else begin
               state_in = S_ZERO;
            end
         end
         S_ZERO: begin
            if (fill_ff == sbsh_pkg::LEN_OFFSET) begin
               lidx_in  = 3'd0;
               state_in = S_LEN;
            end else begin
               cmd.push     = 1'b1;
               cmd.byte_sel = sbsh_pkg::BSEL_ZERO;
               fill_in      = fill_ff + 6'd1;
               if (full) begin
                  cmd.init_work = 1'b1;
                  ret_in        = S_ZERO;
                  state_in      = S_ROUND;
               end
            end
         end
         S_LEN: begin
            cmd.push     = 1'b1;
            cmd.byte_sel = sbsh_pkg::BSEL_LEN;
            fill_in      = fill_ff + 6'd1;
            lidx_in      = lidx_ff + 3'd1;
            if (lidx_ff == 3'd7) begin
               cmd.init_work = 1'b1;
               ret_in        = S_DONE;
               state_in      = S_ROUND;
            end
         end
         S_ROUND: begin
            cmd.do_round = 1'b1;
            round_in     = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            cmd.fold = 1'b1;
            state_in = ret_ff;
         end
         S_DONE: begin
            if (!status.out_busy) begin
               cmd.digest_load = 1'b1;
               state_in        = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         ret_ff   <= S_LOAD;
         fill_ff  <= 6'd0;
         round_ff <= 6'd0;
         lidx_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         fill_ff  <= fill_in;
         round_ff <= round_in;
         lidx_ff  <= lidx_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/sbsh_datapath.sv =====
// Datapath of the hasher: block line and message schedule, round logic, chain value,
// length counter and digest output register. Depends on sbsh_pkg.
`default_nettype none

module sbsh_datapath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sbsh_pkg::ctrl_cmd_type cmd,
   output sbsh_pkg::dp_status_type    status,
   input  wire logic [7:0]            data_byte,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [63:0]                digest_part,
   output logic                       digest_end
);

   function automatic sbsh_pkg::word_type rotr(input sbsh_pkg::word_type x,
                                               input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   sbsh_pkg::word_type w_ff [16];
   sbsh_pkg::word_type w_in [16];
   sbsh_pkg::word_type wk_ff [8];
   sbsh_pkg::word_type wk_in [8];
   sbsh_pkg::word_type chain_ff [8];
   sbsh_pkg::word_type chain_in [8];
   logic [63:0]  len_ff, len_in;
   logic [255:0] dig_ff, dig_in;
   logic [2:0]   cnt_ff, cnt_in;

   logic [63:0]        len_bits;
   logic [7:0]         len_byte;
   logic [7:0]         push_byte;
   sbsh_pkg::word_type new_w, sig0, sig1;
   sbsh_pkg::word_type big0, big1, choose, major, tmp1, tmp2;

   // Length byte, most significant first, of the bit count.
   assign len_bits = {len_ff[60:0], 3'b000};
   assign len_byte = len_bits[{3'd7 - cmd.len_idx, 3'b000} +: 8];

   always_comb begin
      unique case (cmd.byte_sel)
         sbsh_pkg::BSEL_DATA: push_byte = data_byte;
         sbsh_pkg::BSEL_PAD:  push_byte = sbsh_pkg::PAD_BYTE;
         sbsh_pkg::BSEL_ZERO: push_byte = 8'h00;
         default:             push_byte = len_byte;
      endcase
   end

   // w_ff[0] always holds the schedule word of the current round.
   assign sig0  = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
   assign sig1  = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
   assign new_w = w_ff[0] + sig0 + w_ff[9] + sig1;

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         w_in[i] = w_ff[i];
      end
      if (cmd.push) begin
         for (int i = 0; i < 15; i++) begin
            w_in[i] = {w_ff[i][23:0], w_ff[i+1][31:24]};
         end
         w_in[15] = {w_ff[15][23:0], push_byte};
      end else if (cmd.do_round) begin
         for (int i = 0; i < 15; i++) begin
            w_in[i] = w_ff[i+1];
         end
         w_in[15] = new_w;
      end
   end

   assign big1   = rotr(wk_ff[4], 6) ^ rotr(wk_ff[4], 11) ^ rotr(wk_ff[4], 25);
   assign choose = (wk_ff[4] & wk_ff[5]) ^ (~wk_ff[4] & wk_ff[6]);
   assign tmp1   = wk_ff[7] + big1 + choose + sbsh_pkg::K_TABLE[cmd.round_idx] + w_ff[0];
   assign big0   = rotr(wk_ff[0], 2) ^ rotr(wk_ff[0], 13) ^ rotr(wk_ff[0], 22);
   assign major  = (wk_ff[0] & wk_ff[1]) ^ (wk_ff[0] & wk_ff[2]) ^ (wk_ff[1] & wk_ff[2]);
   assign tmp2   = big0 + major;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         wk_in[i] = wk_ff[i];
      end
      if (cmd.init_work) begin
         for (int i = 0; i < 8; i++) begin
            wk_in[i] = chain_ff[i];
         end
      end else if (cmd.do_round) begin
         wk_in[0] = tmp1 + tmp2;
         wk_in[1] = wk_ff[0];
         wk_in[2] = wk_ff[1];
         wk_in[3] = wk_ff[2];
         wk_in[4] = wk_ff[3] + tmp1;
         wk_in[5] = wk_ff[4];
         wk_in[6] = wk_ff[5];
         wk_in[7] = wk_ff[6];
      end
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         chain_in[i] = chain_ff[i];
      end
      len_in = len_ff;
      if (cmd.digest_load) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = sbsh_pkg::IV[i];
         end
         len_in = 64'd0;
      end else begin
         if (cmd.fold) begin
            for (int i = 0; i < 8; i++) begin
               chain_in[i] = chain_ff[i] + wk_ff[i];
            end
         end
         if (cmd.count_len) begin
            len_in = len_ff + 64'd1;
         end
      end
   end

   assign rsp_valid       = (cnt_ff != 3'd0);
   assign digest_part     = dig_ff[255:192];
   assign digest_end      = (cnt_ff == 3'd1);
   assign status.out_busy = rsp_valid;

   always_comb begin
      dig_in = dig_ff;
      cnt_in = cnt_ff;
      if (cmd.digest_load) begin
         dig_in = {chain_ff[0], chain_ff[1], chain_ff[2], chain_ff[3],
                   chain_ff[4], chain_ff[5], chain_ff[6], chain_ff[7]};
         cnt_in = 3'd4;
      end else if (rsp_valid && rsp_ready) begin
         dig_in = {dig_ff[191:0], 64'd0};
         cnt_in = cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 16; i++) begin
         w_ff[i] <= w_in[i];
      end
      for (int i = 0; i < 8; i++) begin
         wk_ff[i] <= wk_in[i];
      end
      dig_ff <= dig_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= sbsh_pkg::IV[i];
         end
         len_ff <= 64'd0;
         cnt_ff <= 3'd0;
      end else begin
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= chain_in[i];
         end
         len_ff <= len_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/sha256_byte_stream_hasher_core.sv =====
// SHA-256 byte stream hasher, top level. Takes message bytes one per transfer and
// returns the 256-bit digest as four 64-bit transfers, first digest bytes first.
// Timing: each filled 64-byte block holds off input while its 64 rounds run on a
// single round unit and the working variables are then folded into the chain.
// After the byte marked last, the padding bytes are pushed one per cycle up to
// the end of the final block, held only while a block that fills on the way is
// compressed (plus a turn state before the length field), which adds one or two
// compressions, and the done state then hands the digest to the output register.
// The output register holds all four digest parts, so the next message is taken
// in while they wait to be transferred; only the next digest hand-off waits for
// the register to empty. Depends on sbsh_pkg, sbsh_req_if, sbsh_rsp_if,
// sbsh_ctrl and sbsh_datapath.
`default_nettype none

module sha256_byte_stream_hasher_core (
   input  wire logic  clock,
   input  wire logic  reset,
   sbsh_req_if.sink   req_chan,
   sbsh_rsp_if.source rsp_chan
);

   sbsh_pkg::ctrl_cmd_type  cmd;
   sbsh_pkg::dp_status_type status;

   // The controller owns the byte count within the block, the padding phases and
   // the round counter. It decides every cycle which byte enters the block line.
   sbsh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last_byte),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // The datapath holds the block line, which doubles as the rolling message
   // schedule, the working variables, the chain value, the byte count and the
   // digest output register that drives the result channel.
   sbsh_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .data_byte   (req_chan.data_byte),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .digest_part (rsp_chan.digest_part),
      .digest_end  (rsp_chan.digest_end)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/sbsh_checker.sv =====
// Port-level checks of the SHA-256 byte stream hasher, bound to its top level.
// Depends only on the top-level ports; no package needed.
`default_nettype none

module sbsh_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_last,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [63:0] rsp_part,
   input wire logic        rsp_end
);

   logic [1:0] part_cnt_ff;
   logic       seen_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         part_cnt_ff  <= 2'd0;
         seen_last_ff <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            part_cnt_ff <= part_cnt_ff + 2'd1;
         end
         if (req_valid && req_ready && req_last) begin
            seen_last_ff <= 1'b1;
         end
      end
   end

   // A stalled result transfer keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_part) && $stable(rsp_end))
      else $error("result changed while stalled");

   // Every fourth result transfer, and only that one, closes a digest.
   a_end_place: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |-> (rsp_end == (part_cnt_ff == 2'd3)))
      else $error("digest end flag out of place");

   // No result before any message has ended.
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      !seen_last_ff |-> !rsp_valid)
      else $error("result without a finished message");

   // Padding always follows the last byte, so input is held off right after it.
   a_pad_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> !req_ready)
      else $error("input taken during padding");

endmodule

bind sha256_byte_stream_hasher_core sbsh_checker u_sbsh_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_last  (req_chan.last_byte),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_part  (rsp_chan.digest_part),
   .rsp_end   (rsp_chan.digest_end)
);

`default_nettype wire

// ===== tb/sbsh_tb_pkg.sv =====
// Scoreboard for the SHA-256 byte stream hasher testbench: a bit-exact SHA-256
// predictor fed with accepted message bytes, and the queue of digest parts it expects.
// Depends on nothing; used by tb_sha256_byte_stream_hasher_core.
package sbsh_tb_pkg;

   localparam logic [31:0] START_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam int          BLOCK_LEN    = 64;
   localparam int          LENGTH_SLOT  = 56;
   localparam logic [7:0]  MARKER_BYTE  = 8'h80;

   class digest_scoreboard;

      typedef struct packed {
         logic [63:0] part;
         logic        last;
      } digest_beat_type;

      digest_beat_type digest_queue [$];
      logic [31:0]  hash_words [8];
      logic [7:0]   block_bytes [BLOCK_LEN];
      int unsigned  fill;
      logic [63:0]  byte_count;
      int unsigned  error_count;

      function new();
         restart();
         error_count = 0;
      endfunction

      function void restart();
         for (int j = 0; j < 8; j++) hash_words[j] = START_HASH[j];
         fill       = 0;
         byte_count = '0;
      endfunction

      function logic [31:0] rotr(logic [31:0] x, int n);
         return (x >> n) | (x << (32 - n));
      endfunction

      function void compress_block();
         logic [31:0] w [64];
         logic [31:0] v [8];
         logic [31:0] s0, s1, ch, maj, t1, t2;
         for (int t = 0; t < 16; t++)
            w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
         for (int t = 16; t < 64; t++) begin
            s0   = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
            s1   = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
         end
         for (int j = 0; j < 8; j++) v[j] = hash_words[j];
         for (int t = 0; t < 64; t++) begin
            s1   = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
            ch   = (v[4] & v[5]) ^ (~v[4] & v[6]);
            t1   = v[7] + s1 + ch + ROUND_K[t] + w[t];
            s0   = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
            maj  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            t2   = s0 + maj;
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
         end
         for (int j = 0; j < 8; j++) hash_words[j] = hash_words[j] + v[j];
      endfunction

      function void absorb(logic [7:0] b);
         block_bytes[fill] = b;
         fill++;
         if (fill == BLOCK_LEN) begin
            compress_block();
            fill = 0;
         end
      endfunction

      // Takes one accepted message byte; on the last byte the padded tail is
      // hashed and the four digest parts join the queue.
      function void take_byte(logic [7:0] data, logic last);
         logic [63:0]     bit_len;
         digest_beat_type beat;
         absorb(data);
         byte_count = byte_count + 64'd1;
         if (!last) return;
         bit_len = byte_count << 3;
         absorb(MARKER_BYTE);
         while (fill != LENGTH_SLOT) absorb(8'h00);
         for (int i = 0; i < 8; i++) absorb(bit_len[8*(7-i) +: 8]);
         for (int k = 0; k < 4; k++) begin
            beat.part = {hash_words[2*k], hash_words[2*k+1]};
            beat.last = (k == 3);
            digest_queue.push_back(beat);
         end
         restart();
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         error_count++;
      endtask

      task check_digest_part(logic [63:0] part, logic last);
         digest_beat_type want;
         if (digest_queue.size() == 0) begin
            report($sformatf("digest transfer %h/%0b with nothing expected", part, last));
            return;
         end
         want = digest_queue.pop_front();
         if (part !== want.part)
            report($sformatf("digest_part got %h, want %h", part, want.part));
         if (last !== want.last)
            report($sformatf("digest_end got %0b, want %0b", last, want.last));
      endtask

      function int pending();
         return digest_queue.size();
      endfunction

   endclass

endpackage

// ===== tb/tb_sha256_byte_stream_hasher_core.sv =====
// Top-level testbench of the SHA-256 byte stream hasher: drives message bytes,
// takes digest parts under random back-pressure and checks them against a predictor.
// Depends on sbsh_req_if, sbsh_rsp_if, sbsh_tb_pkg and sha256_byte_stream_hasher_core.
module tb_sha256_byte_stream_hasher_core;

   timeunit 1ns;
   timeprecision 1ps;

   // The longest correct gap without any transfer is the pressure hold below plus
   // a few compressions; the watchdog limit is several times that.
   localparam int HOLD_CYCLES   = 1500;
   localparam int STALL_LIMIT   = 8000;
   localparam int DRAIN_CYCLES  = 400;
   localparam int IDLE_PERCENT  = 19;
   localparam int RANDOM_BYTES  = 210;

   logic clock = 1'b0;
   logic reset;

   sbsh_req_if req_bus ();
   sbsh_rsp_if rsp_bus ();

   sha256_byte_stream_hasher_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   sbsh_tb_pkg::digest_scoreboard digest_sb = new();

   // While calm is set neither side idles, which gives a stretch at full rate.
   bit          calm = 1'b0;
   int unsigned stall_cycles = 0;
   int unsigned parts_taken = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Sends one byte: random idle cycles first, then valid is held until the
   // transfer happens. The predictor sees the byte at the accepting edge.
   task send_byte(logic [7:0] data, logic last);
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= data;
      req_bus.last_byte <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      digest_sb.take_byte(data, last);
   endtask

   task send_message(int len);
      for (int i = 0; i < len; i++)
         send_byte(8'($urandom_range(255)), i == len - 1);
   endtask

   // Counts cycles without any transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("watchdog: %0d cycles without a transfer", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   // Receiver. Checks every completed transfer, idles at random, and once, after
   // the second digest, holds ready low long enough that the output register stays
   // full, the next digest cannot be handed off and the input side stalls.
   initial begin : receiver
      int  hold_left;
      bit  hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_bus.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            digest_sb.check_digest_part(rsp_bus.digest_part, rsp_bus.digest_end);
            parts_taken++;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (!hold_done && parts_taken >= 8) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   initial begin : stimulus
      int lens [$];
      int total;
      int pick;
      int swap;
      req_bus.valid     <= 1'b0;
      req_bus.data_byte <= 8'h00;
      req_bus.last_byte <= 1'b0;
      reset <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: single-byte messages at both byte extremes, the classic
      // three-byte "abc" vector, alternating bit patterns, and a short ramp.
      send_byte(8'h00, 1'b1);
      send_byte(8'hff, 1'b1);
      send_byte(8'h61, 1'b0);
      send_byte(8'h62, 1'b0);
      send_byte(8'h63, 1'b1);
      send_byte(8'h55, 1'b0);
      send_byte(8'haa, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h7f, 1'b1);
      for (int i = 0; i < 16; i++)
         send_byte(8'(i * 17), i == 15);

      // Random part. A message of 55 bytes leaves room for the length in its own
      // block, 56 bytes forces an extra padding block, and 64 bytes fills a block
      // exactly so that the padding needs a block of its own. Short messages fill
      // the rest, in shuffled order; the running total also counts the 25 bytes
      // of the directed part.
      lens.push_back(55);
      lens.push_back(56);
      lens.push_back(64);
      total = 200;
      while (total < RANDOM_BYTES) begin
         pick = $urandom_range(12, 1);
         lens.push_back(pick);
         total += pick;
      end
      for (int i = lens.size() - 1; i > 0; i--) begin
         pick = $urandom_range(i);
         swap = lens[i];
         lens[i] = lens[pick];
         lens[pick] = swap;
      end
      foreach (lens[m]) begin
         calm = (m >= 2 && m <= 4);
         send_message(lens[m]);
      end
      calm = 1'b0;
      @(posedge clock);
      req_bus.valid <= 1'b0;

      // Drain: wait for every expected part, then give the block time to show
      // any stray transfer. The watchdog bounds the wait.
      while (digest_sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (digest_sb.error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/sbsh_pkg.sv
hw/rtl/sbsh_req_if.sv
hw/rtl/sbsh_rsp_if.sv
hw/rtl/sbsh_ctrl.sv
hw/rtl/sbsh_datapath.sv
hw/rtl/sha256_byte_stream_hasher_core.sv
hw/rtl/sbsh_checker.sv
tb/sbsh_tb_pkg.sv
tb/tb_sha256_byte_stream_hasher_core.sv
